### rtl/ppmfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppmfe_pkg
// Types and constants shared by the PPM frame encoder.
// ----------------------------------------------------------------------------
package ppmfe_pkg;

    localparam int DEFAULT_MAX_CHANNELS = 16;

    // Timing constants, all in 0.5 us ticks.
    localparam int CENTER_TICKS     = 2400;
    localparam int RANGE_NORMAL     = 1024;
    localparam int RANGE_EXTENDED   = 1280;
    localparam int BASE_FRAME       = 45000;
    localparam int PER_CHANNEL_LONG = 3440;
    localparam int LONG_FRAME_PAD   = 8000;
    localparam int MARK_OFFSET      = 600;
    localparam int FRAME_STEP       = 1000;
    localparam int GAP_BASE2        = 600;   // gap base of 300 us, doubled
    localparam int GAP_STEP2        = 100;   // gap step of 50 us, doubled

    // Widths that follow from the value ranges.
    localparam int CH_W     = 12;   // channel value
    localparam int VAL_W    = 12;   // centered value, 1120..3680
    localparam int Q_W      = 11;   // gap length, 200..1600
    localparam int P_W      = 5;    // channel count, 4..16
    localparam int REM_W    = 17;   // frame remainder, at most 88640
    localparam int DUR_W    = 16;   // segment duration
    localparam int CFG_W    = 6;    // widest configuration register
    localparam int CFG_A_W  = 2;
    localparam int S_DATA_W = 16;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_EXTENDED_RANGE = 2'd0,
        CFG_EXTRA_PAIRS    = 2'd1,
        CFG_GAP_SETTING    = 2'd2,
        CFG_FRAME_ADJUST   = 2'd3
    } cfg_addr_t;

    // Beat position within one item's results.
    typedef enum logic [1:0] {
        BEAT_GAP   = 2'd0,
        BEAT_MARK  = 2'd1,
        BEAT_FGAP  = 2'd2,
        BEAT_SYNC  = 2'd3
    } beat_t;

endpackage : ppmfe_pkg
`default_nettype wire

### rtl/ppm_frame_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppm_frame_encoder
// Turns a stream of signed channel values into PPM pulse segments in ticks.
//
//   Channel   Dir  Beat content
//   s_axis    in   tdata[11:0] channel_value (signed)
//   m_axis    out  tdata duration_ticks, tuser is_gap, tlast frame_last
//   cfg       in   cfg_addr selects the register, cfg_wdata is the value
//
// An input beat is registered, then turned into its segments and loaded
// into the result register. Each item yields two output beats, or four on
// the last channel of a frame; while m_tready stays high, a waiting item
// is loaded in the same cycle that the last beat of the one before is taken.
// Reset is synchronous and active low; it clears the control and
// configuration registers, and s_tready stays low while it is asserted.
// A stall on m_axis holds the current beat and, once the input register is
// full, drops s_tready.
// ----------------------------------------------------------------------------
module ppm_frame_encoder #(
    parameter int MAX_CHANNELS = ppmfe_pkg::DEFAULT_MAX_CHANNELS
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               s_tvalid,
    output      logic                               s_tready,
    input  wire logic [ppmfe_pkg::S_DATA_W-1:0]     s_tdata,  // [11:0] channel_value

    output      logic                               m_tvalid,
    input  wire logic                               m_tready,
    output      logic [ppmfe_pkg::DUR_W-1:0]        m_tdata,  // [15:0] duration_ticks
    output      logic                               m_tuser,  // [0] is_gap
    output      logic                               m_tlast,

    input  wire logic                               cfg_wr_en,
    input  wire logic [ppmfe_pkg::CFG_A_W-1:0]      cfg_addr,
    input  wire logic [ppmfe_pkg::CFG_W-1:0]        cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_CHANNELS);
    localparam int P_W   = ppmfe_pkg::P_W;
    localparam int Q_W   = ppmfe_pkg::Q_W;
    localparam int REM_W = ppmfe_pkg::REM_W;
    localparam int VAL_W = ppmfe_pkg::VAL_W;
    localparam int DUR_W = ppmfe_pkg::DUR_W;
    localparam int CH_W  = ppmfe_pkg::CH_W;

    // Configuration registers.
    logic               cfg_ext_reg;
    logic [3:0]         cfg_pairs_reg;
    logic [4:0]         cfg_gap_reg;
    logic [5:0]         cfg_fla_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_ext_reg   <= 1'b0;
            cfg_pairs_reg <= '0;
            cfg_gap_reg   <= '0;
            cfg_fla_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (ppmfe_pkg::cfg_addr_t'(cfg_addr))
                ppmfe_pkg::CFG_EXTENDED_RANGE: cfg_ext_reg   <= cfg_wdata[0];
                ppmfe_pkg::CFG_EXTRA_PAIRS:    cfg_pairs_reg <= cfg_wdata[3:0];
                ppmfe_pkg::CFG_GAP_SETTING:    cfg_gap_reg   <= cfg_wdata[4:0];
                ppmfe_pkg::CFG_FRAME_ADJUST:   cfg_fla_reg   <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    // Frame parameters derived from the configuration, registered once.
    logic signed [3:0]  pairs_c;
    logic signed [4:0]  gs_c;
    logic signed [5:0]  fla_c;
    logic signed [5:0]  p_wide;
    logic [P_W-1:0]     p_raw;
    logic [P_W-1:0]     p_next;
    logic signed [11:0] q_wide;
    logic [Q_W-1:0]     q_next;
    logic signed [16:0] fla_ticks;
    logic signed [17:0] short_load;
    logic [12:0]        per_chan;
    logic [17:0]        long_prod;
    logic [17:0]        long_load;
    logic [REM_W-1:0]   load_next;

    logic [P_W-1:0]     p_reg;
    logic [Q_W-1:0]     q_reg;
    logic [REM_W-1:0]   load_reg;

    always_comb begin
        pairs_c = $signed(cfg_pairs_reg);
        if (pairs_c < -4'sd2) begin
            pairs_c = -4'sd2;
        end else if (pairs_c > 4'sd4) begin
            pairs_c = 4'sd4;
        end
        p_wide = 6'sd8 + $signed({pairs_c[3], pairs_c, 1'b0});
        p_raw  = p_wide[P_W-1:0];
        p_next = (p_raw > P_W'(MAX_CHANNELS)) ? P_W'(MAX_CHANNELS) : p_raw;

        gs_c = $signed(cfg_gap_reg);
        if (gs_c < -5'sd4) begin
            gs_c = -5'sd4;
        end else if (gs_c > 5'sd10) begin
            gs_c = 5'sd10;
        end
        q_wide = $signed({{7{gs_c[4]}}, gs_c}) * 12'(ppmfe_pkg::GAP_STEP2)
                 + 12'(ppmfe_pkg::GAP_BASE2);
        q_next = q_wide[Q_W-1:0];

        fla_c = $signed(cfg_fla_reg);
        if (fla_c < -6'sd20) begin
            fla_c = -6'sd20;
        end else if (fla_c > 6'sd20) begin
            fla_c = 6'sd20;
        end
        fla_ticks  = $signed({{11{fla_c[5]}}, fla_c}) * 17'(ppmfe_pkg::FRAME_STEP);
        short_load = 18'(ppmfe_pkg::BASE_FRAME) - 18'(q_next)
                     + $signed({fla_ticks[16], fla_ticks});

        per_chan  = 13'(ppmfe_pkg::PER_CHANNEL_LONG) + 13'(q_next);
        long_prod = 18'(p_next) * 18'(per_chan);
        long_load = long_prod + 18'(ppmfe_pkg::LONG_FRAME_PAD);

        // Both load values are positive over the whole clamped range.
        load_next = (p_next > P_W'(9)) ? long_load[REM_W-1:0] : short_load[REM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        p_reg    <= p_next;
        q_reg    <= q_next;
        load_reg <= load_next;
    end

    // Input register.
    logic                   in_valid_reg;
    logic signed [CH_W-1:0] in_value_reg;
    logic                   load_res;
    logic                   res_done;

    assign s_tready = aresetn && (!in_valid_reg || load_res);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_value_reg <= $signed(s_tdata[CH_W-1:0]);
        end
    end

    // Segment computation for the item in the input register.
    logic [IDX_W-1:0]       idx_reg;
    logic [REM_W-1:0]       rem_reg;
    logic signed [CH_W-1:0] rng;
    logic signed [CH_W-1:0] ch_c;
    logic [12:0]            v_sum;
    logic [VAL_W-1:0]       v;
    logic [12:0]            mark_sum;
    logic [12:0]            vq;
    logic [REM_W-1:0]       rem_base;
    logic [REM_W:0]         diff;
    logic [REM_W-1:0]       rem_next;
    logic [DUR_W-1:0]       sync_next;
    logic                   last_next;

    always_comb begin
        rng  = cfg_ext_reg ? CH_W'(ppmfe_pkg::RANGE_EXTENDED) : CH_W'(ppmfe_pkg::RANGE_NORMAL);
        ch_c = in_value_reg;
        if (ch_c < -rng) begin
            ch_c = -rng;
        end else if (ch_c > rng) begin
            ch_c = rng;
        end
        v_sum    = {ch_c[CH_W-1], ch_c} + 13'(ppmfe_pkg::CENTER_TICKS);
        v        = v_sum[VAL_W-1:0];
        mark_sum = 13'(v) + 13'(ppmfe_pkg::MARK_OFFSET) - 13'(q_reg);
        vq       = 13'(v) + 13'(q_reg);

        rem_base = (idx_reg == '0) ? load_reg : rem_reg;
        diff     = {1'b0, rem_base} - (REM_W+1)'(vq);
        rem_next = diff[REM_W] ? '0 : diff[REM_W-1:0];
        sync_next = (rem_next[REM_W-1:DUR_W] != '0) ? '1 : rem_next[DUR_W-1:0];

        last_next = (P_W'(idx_reg) + P_W'(1)) >= p_reg;
    end

    // Result register, drained one beat per cycle while m_tready is high.
    logic                   res_valid_reg;
    logic                   res_long_reg;
    logic [1:0]             ptr_reg;
    logic [Q_W-1:0]         res_q_reg;
    logic [VAL_W-1:0]       res_mark_reg;
    logic [DUR_W-1:0]       res_sync_reg;

    assign res_done = res_valid_reg && m_tready
                      && (ptr_reg == (res_long_reg ? 2'(ppmfe_pkg::BEAT_SYNC)
                                                   : 2'(ppmfe_pkg::BEAT_MARK)));
    assign load_res = in_valid_reg && (!res_valid_reg || res_done);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
            res_long_reg  <= 1'b0;
            ptr_reg       <= '0;
            idx_reg       <= '0;
            rem_reg       <= '0;
        end else begin
            if (load_res) begin
                res_valid_reg <= 1'b1;
                res_long_reg  <= last_next;
                ptr_reg       <= '0;
                rem_reg       <= rem_next;
                idx_reg       <= last_next ? '0 : idx_reg + IDX_W'(1);
            end else if (res_done) begin
                res_valid_reg <= 1'b0;
            end else if (res_valid_reg && m_tready) begin
                ptr_reg <= ptr_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_res) begin
            res_q_reg    <= q_reg;
            res_mark_reg <= mark_sum[VAL_W-1:0];
            res_sync_reg <= sync_next;
        end
    end

    assign m_tvalid = res_valid_reg;

    always_comb begin
        unique case (ppmfe_pkg::beat_t'(ptr_reg))
            ppmfe_pkg::BEAT_GAP: begin
                m_tdata = DUR_W'(res_q_reg);
                m_tuser = 1'b1;
                m_tlast = 1'b0;
            end
            ppmfe_pkg::BEAT_MARK: begin
                m_tdata = DUR_W'(res_mark_reg);
                m_tuser = 1'b0;
                m_tlast = 1'b0;
            end
            ppmfe_pkg::BEAT_FGAP: begin
                m_tdata = DUR_W'(res_q_reg);
                m_tuser = 1'b1;
                m_tlast = 1'b0;
            end
            ppmfe_pkg::BEAT_SYNC: begin
                m_tdata = res_sync_reg;
                m_tuser = 1'b0;
                m_tlast = 1'b1;
            end
            default: begin
                m_tdata = '0;
                m_tuser = 1'b0;
                m_tlast = 1'b0;
            end
        endcase
    end

    // A computed item shows up at the output on its first beat.
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load_res |=> (m_tvalid && ptr_reg == 2'(ppmfe_pkg::BEAT_GAP)))
        else $error("loaded item did not start at its first beat");

    // Within a frame the remainder only shrinks.
    a_rem_falls: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_res && idx_reg != '0) |=> (rem_reg <= $past(rem_reg)))
        else $error("frame remainder grew within a frame");

    // Closing a frame restarts the channel count.
    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_res && last_next) |=> (idx_reg == '0 && res_long_reg))
        else $error("channel index not cleared after frame close");

endmodule : ppm_frame_encoder
`default_nettype wire

### sim/tb_ppm_frame_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ppm_frame_encoder
// Self-checking bench for the PPM frame encoder.
//
// A short table of channel values and register writes exercises clamping,
// register saturation, a frame closed early by a shrinking channel count,
// sync saturation and remainder underflow. Randomized bursts with random
// register settings follow. Every accepted channel beat is run through a
// local model of the encoder, and each segment beat on the output is
// compared against the oldest predicted segment.
// ----------------------------------------------------------------------------
module tb_ppm_frame_encoder;

    localparam int MAX_CH        = ppmfe_pkg::DEFAULT_MAX_CHANNELS;
    localparam int NO_MARK       = -1;
    localparam int RANDOM_ITEMS  = 145;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 80;
    localparam int MAX_REPORTS   = 10;

    // Encoder constants, in 0.5 us ticks; the gap base and step are in us.
    localparam int T_CENTER    = 2400;
    localparam int T_SPAN      = 1024;
    localparam int T_SPAN_WIDE = 1280;
    localparam int T_FRAME     = 45000;
    localparam int T_PER_CH    = 3440;
    localparam int T_PAD       = 8000;
    localparam int T_MARK_ADD  = 600;
    localparam int T_ADJ_STEP  = 1000;
    localparam int T_GAP_BASE  = 300;
    localparam int T_GAP_STEP  = 50;

    typedef struct packed {
        logic [15:0] ticks;
        logic        is_gap;
        logic        frame_last;
    } segment_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        ppmfe_pkg::cfg_addr_t  addr;
        logic [5:0]            value;
        logic [11:0]           chan;
        int                    mark;
    } stim_row_t;

    // Directed stimulus. Marks are typed in only where they follow directly
    // from the clamp and the gap length of that phase.
    localparam int N_ROWS = 28;
    stim_row_t plan [N_ROWS] = '{
        // Reset settings: 8 channels, 600-tick gap, narrow clamp.
        '{ROW_ITEM, ppmfe_pkg::CFG_EXTENDED_RANGE, 6'h00, 12'h000, 2400},
        '{ROW_ITEM, ppmfe_pkg::CFG_EXTENDED_RANGE, 6'h00, 12'h800, 1376},
        '{ROW_ITEM, ppmfe_pkg::CFG_EXTENDED_RANGE, 6'h00, 12'h7FF, 3424},
        '{ROW_ITEM, ppmfe_pkg::CFG_EXTENDED_RANGE, 6'h00, 12'hC00, 1376},
        '{ROW_ITEM, ppmfe_pkg::CFG_EXTENDED_RANGE, 6'h00, 12'h400, 3424},
        '{ROW_ITEM, ppmfe_pkg::CFG_EXTENDED_RANGE, 6'h00, 12'hBFF, 1376},
        '{ROW_ITEM, ppmfe_pkg::CFG_EXTENDED_RANGE, 6'h00, 12'h401, 3424},
        '{ROW_ITEM, ppmfe_pkg::CFG_EXTENDED_RANGE, 6'h00, 12'h555, NO_MARK},
        // Wide clamp, out-of-range pair count and gap that saturate high.
        '{ROW_CFG,  ppmfe_pkg::CFG_EXTENDED_RANGE, 6'h01, 12'h000, NO_MARK},
        '{ROW_CFG,  ppmfe_pkg::CFG_EXTRA_PAIRS,    6'h07, 12'h000, NO_MARK},
        '{ROW_CFG,  ppmfe_pkg::CFG_GAP_SETTING,    6'h0F, 12'h000, NO_MARK},
        '{ROW_ITEM, ppmfe_pkg::CFG_EXTENDED_RANGE, 6'h00, 12'h800, 120},
        '{ROW_ITEM, ppmfe_pkg::CFG_EXTENDED_RANGE, 6'h00, 12'h800, 120},
        '{ROW_ITEM, ppmfe_pkg::CFG_EXTENDED_RANGE, 6'h00, 12'h800, 120},
        '{ROW_ITEM, ppmfe_pkg::CFG_EXTENDED_RANGE, 6'h00, 12'h800, 120},
        '{ROW_ITEM, ppmfe_pkg::CFG_EXTENDED_RANGE, 6'h00, 12'h800, 120},
        // Channel count drops below the current slot: the next beat closes
        // the frame and its sync exceeds 16 bits.
        '{ROW_CFG,  ppmfe_pkg::CFG_EXTRA_PAIRS,    6'h08, 12'h000, NO_MARK},
        '{ROW_ITEM, ppmfe_pkg::CFG_EXTENDED_RANGE, 6'h00, 12'h7FF, 2680},
        // Shortest frame with the longest gaps runs the remainder dry.
        '{ROW_CFG,  ppmfe_pkg::CFG_EXTRA_PAIRS,    6'h00, 12'h000, NO_MARK},
        '{ROW_CFG,  ppmfe_pkg::CFG_FRAME_ADJUST,   6'h20, 12'h000, NO_MARK},
        '{ROW_ITEM, ppmfe_pkg::CFG_EXTENDED_RANGE, 6'h00, 12'h500, 2680},
        '{ROW_ITEM, ppmfe_pkg::CFG_EXTENDED_RANGE, 6'h00, 12'h501, 2680},
        '{ROW_ITEM, ppmfe_pkg::CFG_EXTENDED_RANGE, 6'h00, 12'hB00, 120},
        '{ROW_ITEM, ppmfe_pkg::CFG_EXTENDED_RANGE, 6'h00, 12'hAFF, 120},
        '{ROW_ITEM, ppmfe_pkg::CFG_EXTENDED_RANGE, 6'h00, 12'h7FF, 2680},
        '{ROW_ITEM, ppmfe_pkg::CFG_EXTENDED_RANGE, 6'h00, 12'h7FF, 2680},
        '{ROW_ITEM, ppmfe_pkg::CFG_EXTENDED_RANGE, 6'h00, 12'h7FF, 2680},
        '{ROW_ITEM, ppmfe_pkg::CFG_EXTENDED_RANGE, 6'h00, 12'h7FF, 2680}
    };

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    ppmfe_pkg::cfg_addr_t  cfg_addr  = ppmfe_pkg::CFG_EXTENDED_RANGE;
    logic [5:0]            cfg_wdata = '0;

    // Local copy of the registers and of the frame state.
    logic        shadow_wide   = 1'b0;
    logic [3:0]  shadow_pairs  = '0;
    logic [4:0]  shadow_gap    = '0;
    logic [5:0]  shadow_adjust = '0;
    logic [4:0]  slot_index    = '0;
    logic [17:0] sync_left     = '0;

    segment_t pending_segments[$];

    int fail_count      = 0;
    int items_accepted  = 0;
    int beats_seen      = 0;
    int frames_closed   = 0;
    int reg_writes      = 0;
    int random_items    = 0;
    int hold_left       = 0;
    bit hold_done       = 1'b0;

    ppm_frame_encoder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [11:0] channel_value
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [15:0] duration_ticks
        .m_tuser   (m_tuser),    // [0] is_gap
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d segment beats outstanding", pending_segments.size());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic void note_failure(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("[%0t] %s", $realtime, what);
        end
    endfunction

    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [15:0] to_ticks(input int d);
        if (d < 0) return 16'd0;
        if (d > 65535) return 16'hFFFF;
        return 16'(d);
    endfunction

    // Works out the segments of one channel beat and queues them. A typed
    // mark, when given, stands in for the computed mark duration.
    function automatic void predict_segments(input logic [11:0] chan, input int typed_mark);
        int pairs;
        int count;
        int gap_sel;
        int adjust;
        int q;
        int span;
        int v;
        int load;
        int rest;
        logic [15:0] mark;

        pairs   = clamp_int(int'($signed(shadow_pairs)), -2, 4);
        gap_sel = clamp_int(int'($signed(shadow_gap)), -4, 10);
        adjust  = clamp_int(int'($signed(shadow_adjust)), -20, 20);
        count   = 8 + 2 * pairs;
        if (count > MAX_CH) count = MAX_CH;
        q    = (gap_sel * T_GAP_STEP + T_GAP_BASE) * 2;
        span = shadow_wide ? T_SPAN_WIDE : T_SPAN;

        if (slot_index == 5'd0) begin
            if (count > 9) load = count * (T_PER_CH + q) + T_PAD;
            else load = T_FRAME - q + adjust * T_ADJ_STEP;
            if (load < 0) load = 0;
            sync_left = 18'(load);
        end

        v    = clamp_int(int'($signed(chan)), -span, span) + T_CENTER;
        rest = int'(sync_left) - (v + q);
        if (rest < 0) rest = 0;
        sync_left = 18'(rest);

        mark = (typed_mark >= 0) ? 16'(typed_mark) : to_ticks(v - q + T_MARK_ADD);
        pending_segments.push_back('{to_ticks(q), 1'b1, 1'b0});
        pending_segments.push_back('{mark, 1'b0, 1'b0});

        if (int'(slot_index) + 1 >= count) begin
            pending_segments.push_back('{to_ticks(q), 1'b1, 1'b0});
            pending_segments.push_back('{to_ticks(int'(sync_left)), 1'b0, 1'b1});
            slot_index = '0;
        end else begin
            slot_index = slot_index + 5'd1;
        end
    endfunction

    // mode 0 picks the low end of the legal range, 1 the high end, anything
    // else a random value that may also lie outside the legal range.
    function automatic logic [5:0] pick_reg(input int lo, input int hi, input int w,
                                            input int mode);
        int val;
        int r;

        r = $urandom_range(0, 99);
        if (mode == 0) val = lo;
        else if (mode == 1) val = hi;
        else if (r < 30) val = ($urandom_range(0, 1) != 0) ? hi : lo;
        else if (r < 50) val = int'($urandom);
        else val = lo + int'($urandom_range(0, hi - lo));
        return 6'(val & ((1 << w) - 1));
    endfunction

    function automatic logic [11:0] pick_channel();
        int r;
        int mag;

        r = $urandom_range(0, 99);
        if (r < 55) return 12'(int'($urandom_range(0, 2048)) - 1024);
        if (r < 75) begin
            case ($urandom_range(0, 3))
                0: mag = T_SPAN;
                1: mag = T_SPAN + 1;
                2: mag = T_SPAN_WIDE;
                default: mag = T_SPAN_WIDE + 1;
            endcase
            return ($urandom_range(0, 1) != 0) ? 12'(-mag) : 12'(mag);
        end
        return 12'($urandom);
    endfunction

    task automatic send_channel(input logic [11:0] chan, input int typed_mark);
        bit steady;

        steady = (items_accepted >= 60 && items_accepted < 110);
        while (!steady && $urandom_range(0, 99) < 26) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, chan};
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        items_accepted++;
        predict_segments(chan, typed_mark);
    endtask

    task automatic write_reg(input ppmfe_pkg::cfg_addr_t addr, input logic [5:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (addr)
            ppmfe_pkg::CFG_EXTENDED_RANGE: shadow_wide   = value[0];
            ppmfe_pkg::CFG_EXTRA_PAIRS:    shadow_pairs  = value[3:0];
            ppmfe_pkg::CFG_GAP_SETTING:    shadow_gap    = value[4:0];
            ppmfe_pkg::CFG_FRAME_ADJUST:   shadow_adjust = value[5:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Stops offering beats and waits until every predicted segment is out.
    task automatic settle(input int limit);
        int waited;

        waited = 0;
        s_tvalid <= 1'b0;
        while (pending_segments.size() != 0 && waited < limit) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_segments.size() != 0) begin
            note_failure($sformatf("%0d segment beats never arrived",
                                   pending_segments.size()));
            pending_segments.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Output side: checks each beat and drives m_tready.
    initial begin
        segment_t exp_seg;

        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid === 1'b1 && m_tready) begin
                beats_seen++;
                if (m_tlast === 1'b1) frames_closed++;
                if (pending_segments.size() == 0) begin
                    note_failure($sformatf("unexpected beat: ticks=%0d gap=%b last=%b",
                                           m_tdata, m_tuser, m_tlast));
                end else begin
                    exp_seg = pending_segments.pop_front();
                    if (m_tdata !== exp_seg.ticks || m_tuser !== exp_seg.is_gap ||
                            m_tlast !== exp_seg.frame_last) begin
                        note_failure($sformatf({"beat %0d: expected ticks=%0d gap=%b last=%b,",
                                                " got ticks=%0d gap=%b last=%b"},
                            beats_seen, exp_seg.ticks, exp_seg.is_gap, exp_seg.frame_last,
                            m_tdata, m_tuser, m_tlast));
                    end
                end
            end

            // One long hold-off while the input side keeps offering beats,
            // so the encoder fills up and stalls its input.
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && beats_seen >= 260 && s_tvalid) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (beats_seen >= 120 && beats_seen < 200) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 26);
            end
        end
    end

    initial begin
        int burst;
        int phase;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_ROWS; i++) begin
            if (plan[i].kind == ROW_CFG) begin
                settle(DRAIN_LIMIT);
                write_reg(plan[i].addr, plan[i].value);
            end else begin
                send_channel(plan[i].chan, plan[i].mark);
            end
        end

        // Random bursts; the first uses every register at its low end and
        // the second at its high end.
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            settle(DRAIN_LIMIT);
            write_reg(ppmfe_pkg::CFG_EXTENDED_RANGE, pick_reg(0, 1, 1, phase));
            write_reg(ppmfe_pkg::CFG_EXTRA_PAIRS, pick_reg(-2, 4, 4, phase));
            write_reg(ppmfe_pkg::CFG_GAP_SETTING, pick_reg(-4, 10, 5, phase));
            write_reg(ppmfe_pkg::CFG_FRAME_ADJUST, pick_reg(-20, 20, 6, phase));
            burst = $urandom_range(4, 30);
            if (burst > RANDOM_ITEMS - random_items) burst = RANDOM_ITEMS - random_items;
            repeat (burst) begin
                send_channel(pick_channel(), NO_MARK);
                random_items++;
            end
            phase++;
        end

        settle(DRAIN_LIMIT);
        $display("Sent %0d channel beats (%0d random) over %0d register settings.",
                 items_accepted, random_items, phase + 4);
        $display("Checked %0d segment beats in %0d closed frames after %0d register writes.",
                 beats_seen, frames_closed, reg_writes);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches in total", fail_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
